### src/clsr_pkg.sv
`default_nettype none

package clsr_pkg;

    // Field widths
    localparam int unsigned VAL_W  = 31;
    localparam int unsigned FRAC_W = 24;
    localparam int unsigned MUL_W  = 16;
    localparam int unsigned FOLD_W = 8;
    localparam int unsigned UPC_W  = 4;

    // Generator constants
    localparam logic [VAL_W-1:0]  MOD1       = 31'd2147483563;
    localparam logic [VAL_W-1:0]  MOD2       = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL1       = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL2       = 16'd40692;
    // 2^31 mod MOD1 and 2^31 mod MOD2
    localparam logic [FOLD_W-1:0] FOLD1      = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD2      = 8'd249;
    localparam logic [VAL_W-1:0]  SEED2_INIT = 31'd123456789;
    localparam logic [FRAC_W-1:0] FRAC_CAP   = 24'd16777214;
    localparam int unsigned       WARMUP_EXTRA = 8;

    // Microcode step addresses
    typedef enum logic [UPC_W-1:0] {
        UPC_IDLE,
        UPC_SEED,
        UPC_WU_ISSUE,
        UPC_WU_WAIT,
        UPC_WU_FILL,
        UPC_D_G1,
        UPC_D_G2,
        UPC_D_IDX,
        UPC_D_RD,
        UPC_D_MIX,
        UPC_D_EMIT
    } upc_t;

    // Sequencing operations
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_DISPATCH,
        SEQ_LOOP,
        SEQ_WAIT_OUT
    } seq_op_t;

    // One control word
    typedef struct packed {
        logic    accept;
        logic    ld_seed;
        logic    issue_g1;
        logic    issue_g2;
        logic    ld_est;
        logic    ld_idx;
        logic    ram_rd;
        logic    mix;
        logic    fill;
        logic    emit;
        seq_op_t seq;
        upc_t    target;
    } ctrl_word_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic req_type;
        logic cnt_zero;
        logic out_free;
    } seq_status_t;

    // Modular multiplier result
    typedef struct packed {
        logic             valid;
        logic             sel2;
        logic [VAL_W-1:0] value;
    } mm_result_t;

endpackage

`default_nettype wire

### src/clsr_if.sv
`default_nettype none

// Request channel
interface clsr_req_if;
    import clsr_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [VAL_W-1:0] seed_value;

    modport source (output valid, req_type, seed_value, input ready);
    modport sink   (input valid, req_type, seed_value, output ready);
endinterface

// Draw result channel
interface clsr_draw_if;
    import clsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  raw_value;
    logic [FRAC_W-1:0] fraction;

    modport source (output valid, raw_value, fraction, input ready);
    modport sink   (input valid, raw_value, fraction, output ready);
endinterface

`default_nettype wire

### src/clsr_ram.sv
`default_nettype none

module clsr_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/clsr_mulmod.sv
`default_nettype none

module clsr_mulmod (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         issue,
    input  wire                         sel2,
    input  wire [clsr_pkg::VAL_W-1:0]   operand,
    output clsr_pkg::mm_result_t        result
);
    import clsr_pkg::*;

    localparam int unsigned PROD_W = VAL_W + MUL_W;
    localparam int unsigned SUM_W  = VAL_W + 1;

    logic              s1_vld_reg, s2_vld_reg;
    logic              s1_sel_reg, s2_sel_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]  fold_reg, fold_next;
    logic [MUL_W-1:0]  mul_sel;
    logic [FOLD_W-1:0] fold_c;
    logic [VAL_W-1:0]  mod_sel;

    // Stage 1: a * x
    always_comb
    begin
        mul_sel   = sel2 ? MUL2 : MUL1;
        prod_next = PROD_W'(operand) * PROD_W'(mul_sel);
    end

    // Stage 2: fold the bits above 2^31 back, since 2^31 = c (mod m)
    always_comb
    begin
        fold_c    = s1_sel_reg ? FOLD2 : FOLD1;
        fold_next = SUM_W'(prod_reg[PROD_W-1:VAL_W]) * SUM_W'(fold_c)
                  + SUM_W'(prod_reg[VAL_W-1:0]);
    end

    // Stage 3: folded sum is below twice the modulus, one subtract
    always_comb
    begin
        mod_sel      = s2_sel_reg ? MOD2 : MOD1;
        result.valid = s2_vld_reg;
        result.sel2  = s2_sel_reg;
        if (fold_reg >= SUM_W'(mod_sel))
        begin
            result.value = VAL_W'(fold_reg - SUM_W'(mod_sel));
        end
        else
        begin
            result.value = VAL_W'(fold_reg);
        end
    end

    // Stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s1_sel_reg <= 1'b0;
            s2_sel_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            s1_sel_reg <= sel2;
            s2_sel_reg <= s1_sel_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        fold_reg <= fold_next;
    end

endmodule

`default_nettype wire

### src/clsr_useq.sv
`default_nettype none

module clsr_useq (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire clsr_pkg::seq_status_t  status,
    output clsr_pkg::ctrl_word_t        ctrl
);
    import clsr_pkg::*;

    upc_t upc_reg, upc_next;

    // Control store
    function automatic ctrl_word_t ucode(input upc_t a);
        ctrl_word_t w;
        w        = '0;
        w.seq    = SEQ_NEXT;
        w.target = UPC_IDLE;
        case (a)
            UPC_IDLE:
            begin
                w.accept = 1'b1;
                w.seq    = SEQ_DISPATCH;
                w.target = UPC_D_G1;
            end
            UPC_SEED:     w.ld_seed  = 1'b1;
            UPC_WU_ISSUE: w.issue_g1 = 1'b1;
            UPC_WU_WAIT:  w.seq      = SEQ_NEXT;
            UPC_WU_FILL:
            begin
                w.fill   = 1'b1;
                w.seq    = SEQ_LOOP;
                w.target = UPC_WU_ISSUE;
            end
            UPC_D_G1:     w.issue_g1 = 1'b1;
            UPC_D_G2:
            begin
                w.issue_g2 = 1'b1;
                w.ld_est   = 1'b1;
            end
            UPC_D_IDX:    w.ld_idx = 1'b1;
            UPC_D_RD:     w.ram_rd = 1'b1;
            UPC_D_MIX:    w.mix    = 1'b1;
            UPC_D_EMIT:
            begin
                w.emit   = 1'b1;
                w.seq    = SEQ_WAIT_OUT;
                w.target = UPC_IDLE;
            end
            default:
            begin
                w.seq    = SEQ_JUMP;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // Control word and next step
    always_comb
    begin
        ctrl = ucode(upc_reg);
        case (ctrl.seq)
            SEQ_NEXT:
            begin
                upc_next = upc_t'(UPC_W'(upc_reg) + UPC_W'(1));
            end
            SEQ_JUMP:
            begin
                upc_next = ctrl.target;
            end
            SEQ_DISPATCH:
            begin
                if (!status.in_valid)
                begin
                    upc_next = upc_reg;
                end
                else if (status.req_type)
                begin
                    upc_next = upc_t'(UPC_W'(upc_reg) + UPC_W'(1));
                end
                else
                begin
                    upc_next = ctrl.target;
                end
            end
            SEQ_LOOP:
            begin
                if (status.cnt_zero)
                begin
                    upc_next = upc_t'(UPC_W'(upc_reg) + UPC_W'(1));
                end
                else
                begin
                    upc_next = ctrl.target;
                end
            end
            SEQ_WAIT_OUT:
            begin
                upc_next = status.out_free ? ctrl.target : upc_reg;
            end
            default:
            begin
                upc_next = UPC_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/combined_lcg_shuffle_random_top.sv
// Draw request: steps D_G1, D_G2, D_IDX, D_RD, D_MIX and D_EMIT run in order after the request
// transfer; D_EMIT holds until the output is free. Reseed request: the seed is loaded, then each
// of the TABLE_ENTRIES+8 warm-up steps goes through the modular multiplier in series, then a draw.
// One request is in work at a time; the next is taken while a result waits in the output.
// Reset: first generator 1, second 123456789, previous output 0; table entries are
// marked empty by per-entry valid flops and read as zero, so no clearing pass is run.
`default_nettype none

module combined_lcg_shuffle_random_top #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    clsr_req_if.sink     req,
    clsr_draw_if.source  draw
);
    import clsr_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned EST_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + WARMUP_EXTRA);
    localparam int unsigned SCL_W = VAL_W + EST_W;
    localparam int unsigned SUM_W = VAL_W + 1;
    localparam int unsigned LOW_W = VAL_W - FRAC_W;
    localparam longint unsigned DIVISOR_L = 64'd1 + (64'd2147483562 / TABLE_ENTRIES);
    localparam logic [VAL_W-1:0] DIVISOR = VAL_W'(DIVISOR_L);

    ctrl_word_t  ctrl;
    seq_status_t status;
    mm_result_t  mm;

    logic [VAL_W-1:0]  g1_reg, g2_reg, prev_reg, seed_reg, raw_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [EST_W-1:0]  est_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic              rd_vld_reg;
    logic              out_vld_reg;

    logic              req_fire, out_free, emit_fire;
    logic [VAL_W-1:0]  seed_eff;
    logic [SCL_W-1:0]  scaled;
    logic [EST_W-1:0]  est_next;
    logic [SUM_W-1:0]  est_prod, est_rem;
    logic [EST_W:0]    quot;
    logic [IDX_W-1:0]  idx_next;
    logic [VAL_W-1:0]  rd_data, entry, y_val;
    logic [SUM_W-1:0]  diff, y_full;
    logic [FRAC_W-1:0] q0, frac_next;
    logic [SUM_W-1:0]  frac_rem;
    logic              fill_hit;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;

    // Sequencer and shared modular multiplier
    clsr_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    clsr_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (ctrl.issue_g1 | ctrl.issue_g2),
        .sel2    (ctrl.issue_g2),
        .operand (ctrl.issue_g2 ? g2_reg : g1_reg),
        .result  (mm)
    );

    // Shuffle table
    clsr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctrl.ram_rd),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Handshake and status
    assign req_fire  = req.valid & ctrl.accept;
    assign out_free  = ~out_vld_reg | draw.ready;
    assign emit_fire = ctrl.emit & out_free;
    assign req.ready = ctrl.accept;

    assign draw.valid     = out_vld_reg;
    assign draw.raw_value = raw_reg;
    assign draw.fraction  = frac_reg;

    always_comb
    begin
        status.in_valid = req.valid;
        status.req_type = req.req_type;
        status.cnt_zero = (cnt_reg == '0);
        status.out_free = out_free;
    end

    assign seed_eff = (seed_reg == '0) ? VAL_W'(1) : seed_reg;

    // Table index: estimate from prev*N/2^31, then at most one step up
    always_comb
    begin
        scaled   = SCL_W'(prev_reg) * SCL_W'(TABLE_ENTRIES);
        est_next = scaled[SCL_W-1:VAL_W];
        est_prod = SUM_W'(est_reg) * SUM_W'(DIVISOR);
        est_rem  = SUM_W'(prev_reg) - est_prod;
        quot     = (EST_W+1)'(est_reg) + (EST_W+1)'(est_rem >= SUM_W'(DIVISOR));
        if (quot > (EST_W+1)'(TABLE_ENTRIES - 1))
        begin
            idx_next = IDX_W'(TABLE_ENTRIES - 1);
        end
        else
        begin
            idx_next = quot[IDX_W-1:0];
        end
    end

    // Combine: entry minus second generator, wrapped into 1 .. MOD1-1
    always_comb
    begin
        entry  = rd_vld_reg ? rd_data : '0;
        diff   = SUM_W'(entry) - SUM_W'(g2_reg);
        if (diff[VAL_W] || diff == '0)
        begin
            y_full = diff + SUM_W'(MOD1 - VAL_W'(1));
        end
        else
        begin
            y_full = diff;
        end
        y_val = y_full[VAL_W-1:0];
    end

    // Fraction: top bits give the quotient by 2^31, 2^31 = 85 (mod MOD1) fixes it
    always_comb
    begin
        q0       = prev_reg[VAL_W-1:LOW_W];
        frac_rem = SUM_W'({prev_reg[LOW_W-1:0], FRAC_W'(0)})
                 + SUM_W'(q0) * SUM_W'(FOLD1);
        if (q0 >= FRAC_CAP)
        begin
            frac_next = FRAC_CAP;
        end
        else
        begin
            frac_next = q0 + FRAC_W'(frac_rem >= SUM_W'(MOD1));
        end
    end

    // Table write port: warm-up fill or draw refill
    always_comb
    begin
        fill_hit  = (cnt_reg < CNT_W'(TABLE_ENTRIES));
        ram_we    = ctrl.mix | (ctrl.fill & fill_hit);
        ram_waddr = ctrl.mix ? idx_reg : cnt_reg[IDX_W-1:0];
        ram_wdata = ctrl.mix ? g1_reg : mm.value;
    end

    // Generator state, previous output, loop counter, entry valid flops and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg      <= VAL_W'(1);
            g2_reg      <= SEED2_INIT;
            prev_reg    <= '0;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.ld_seed)
            begin
                g1_reg <= seed_eff;
                g2_reg <= seed_eff;
            end
            else
            begin
                if (mm.valid && !mm.sel2)
                begin
                    g1_reg <= mm.value;
                end
                if (mm.valid && mm.sel2)
                begin
                    g2_reg <= mm.value;
                end
            end

            if (ctrl.fill)
            begin
                prev_reg <= mm.value;
            end
            else if (ctrl.mix)
            begin
                prev_reg <= y_val;
            end

            if (ctrl.ld_seed)
            begin
                cnt_reg <= CNT_W'(TABLE_ENTRIES + WARMUP_EXTRA - 1);
            end
            else if (ctrl.fill)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end

            if (ctrl.ram_rd)
            begin
                rd_vld_reg <= valid_reg[idx_reg];
            end

            if (emit_fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (draw.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            seed_reg <= req.seed_value;
        end
        if (ctrl.ld_est)
        begin
            est_reg <= est_next;
        end
        if (ctrl.ld_idx)
        begin
            idx_reg <= idx_next;
        end
        if (emit_fire)
        begin
            raw_reg  <= prev_reg;
            frac_reg <= frac_next;
        end
    end

    // Warm-up result lands on the fill step
    a_fill_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fill |-> (mm.valid && !mm.sel2))
        else $error("warm-up fill without first generator result");

    // Both generator updates are done before the combine step
    a_mix_settled: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mix |-> !mm.valid)
        else $error("combine step while multiplier still busy");

    // Emitted value lies in 1 .. MOD1-1
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (prev_reg != '0 && prev_reg < MOD1))
        else $error("draw value out of range");

    // One request in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("request taken while busy");

endmodule

`default_nettype wire
